/* rtl/core/tkg_pkg.sv */
// ----------------------------------------------------------------------------
// tkg_pkg: shared types and constants of the telemetry KLV position extractor
// Holds the request structs, KLV keys and type codes, and the parameter defaults.
// ----------------------------------------------------------------------------
package tkg_pkg;

	localparam int SCALE_ENTRIES_DEF = 5;
	localparam int FRACTION_BITS_DEF = 32;

	localparam logic [31:0] KEY_GPSF    = 32'h47505346;
	localparam logic [31:0] KEY_GPS5    = 32'h47505335;
	localparam logic [31:0] KEY_SCAL    = 32'h5343414C;
	localparam logic [7:0]  TYPE_NEST   = 8'h00;
	localparam logic [7:0]  TYPE_ULONG  = 8'h4C;
	localparam logic [7:0]  TYPE_USHORT = 8'h53;
	localparam logic [7:0]  TYPE_SSHORT = 8'h73;
	localparam logic [7:0]  TYPE_UTC    = 8'h55;
	localparam logic [3:0]  ELEM_IDX_MAX = 4'd15;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_end;
	} in_req_t;

	typedef struct packed {
		logic [31:0]        gps_fix;
		logic signed [63:0] latitude_q;
		logic signed [63:0] longitude_q;
		logic signed [63:0] elevation_q;
		logic               position_seen;
		logic [6:0]         utc_year;
		logic [6:0]         utc_month;
		logic [6:0]         utc_day;
		logic [6:0]         utc_hour;
		logic [6:0]         utc_minute;
		logic [6:0]         utc_second;
		logic [9:0]         utc_millis;
	} out_req_t;

	// Start request and result of the shared divider.
	typedef struct packed {
		logic        start;
		logic [31:0] raw;
		logic [31:0] scale;
	} div_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
	} div_rsp_t;

	function automatic logic [3:0] digit_val(input logic [7:0] c);
		logic [7:0] d;
		d = c - 8'h30;
		return (c >= 8'h30 && c <= 8'h39) ? d[3:0] : 4'd0;
	endfunction

endpackage

/* rtl/core/tkg_divider.sv */
// ----------------------------------------------------------------------------
// tkg_divider: shared restoring divider, one quotient bit per cycle
// Computes sign(raw) * ((|raw| << FRACTION_BITS) / scale), saturating when scale is zero.
// ----------------------------------------------------------------------------
module tkg_divider #(
	parameter int FRACTION_BITS = tkg_pkg::FRACTION_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tkg_pkg::div_cmd_t cmd,
	output tkg_pkg::div_rsp_t rsp
);
	localparam int NB = 32 + FRACTION_BITS;
	localparam int CW = $clog2(NB + 1);

	logic [NB-1:0] num_q;
	logic [NB-1:0] quo_q;
	logic [32:0]   rem_q;
	logic [31:0]   scale_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [63:0]   res_q;

	logic [32:0] trial;
	logic [32:0] diff;
	logic [31:0] mag;
	logic [63:0] qext;

	assign mag   = cmd.raw[31] ? (~cmd.raw + 32'd1) : cmd.raw;
	assign trial = {rem_q[31:0], num_q[NB-1]};
	assign diff  = trial - {1'b0, scale_q};
	assign qext  = 64'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				neg_q   <= cmd.raw[31];
				scale_q <= cmd.scale;
				num_q   <= {mag, {FRACTION_BITS{1'b0}}};
				rem_q   <= '0;
				quo_q   <= '0;
				cnt_q   <= CW'(NB);
				if (cmd.scale == 32'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					if (cmd.raw == 32'd0) begin
						res_q <= 64'd0;
					end else if (cmd.raw[31]) begin
						res_q <= 64'h8000000000000000;
					end else begin
						res_q <= 64'h7FFFFFFFFFFFFFFF;
					end
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					res_q  <= neg_q ? (64'd0 - qext) : qext;
				end else begin
					num_q <= {num_q[NB-2:0], 1'b0};
					if (!diff[32]) begin
						rem_q <= diff;
						quo_q <= {quo_q[NB-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[NB-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = res_q;
endmodule

/* rtl/core/telemetry_klv_gps_extractor_core.sv */
// ----------------------------------------------------------------------------
// telemetry_klv_gps_extractor_core: KLV telemetry parser with GPS extraction
// Walks KLV headers byte by byte, captures scales, fix, first GPS5 sample and
// the UTC digits, and on the packet end emits fixed-point position quotients.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall   | tkg_pkg::in_req_t (byte, last)
// out     | output    | out_valid / out_stall | tkg_pkg::out_req_t (result)
//
// An ordinary byte is parsed in the cycle it is accepted, so bytes may follow
// back to back. A byte marked as the packet end starts three divisions on the
// one shared divider, one after another, at one quotient bit a cycle; the
// result is registered once the third quotient has come back. A division
// by a zero scale saturates at once.
// Input stalls until all three are done and the result is registered.
// The result waits in an output register while the next packet streams in;
// a new packet end stalls only if that register is still full.
// Reset clears all parse state and loads the UTC digits with ASCII zeros.
// ----------------------------------------------------------------------------
module telemetry_klv_gps_extractor_core #(
	parameter int SCALE_ENTRIES = tkg_pkg::SCALE_ENTRIES_DEF,
	parameter int FRACTION_BITS = tkg_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tkg_pkg::in_req_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tkg_pkg::out_req_t  out_data
);
	localparam int SW = $clog2(SCALE_ENTRIES);

	typedef enum logic [1:0] {ST_PARSE, ST_DIV, ST_WAIT} state_t;

	state_t       state_q;
	logic [1:0]   div_sel_q;
	logic         div_go_q;

	logic [63:0]  hdr_q;
	logic [2:0]   hdr_pos_q;
	logic [23:0]  remain_q;
	logic [1:0]   pad_q;
	logic [2:0]   ebp_q;
	logic [31:0]  eshift_q;
	logic [3:0]   eidx_q;
	logic [4:0]   utc_off_q;
	logic [31:0]  scale_q [SCALE_ENTRIES];
	logic [31:0]  fix_q;
	logic [31:0]  raw_q [3];
	logic [31:0]  pscale_q [3];
	logic         pflag_q;
	logic [7:0]   utc_q [16];

	// Snapshot of the finished packet, divided while the input is stalled.
	logic [31:0]  snap_raw_q [3];
	logic [31:0]  snap_scale_q [3];
	logic [63:0]  quot_q [2];
	tkg_pkg::out_req_t res_q;
	tkg_pkg::out_req_t out_q;
	logic         out_valid_q;

	tkg_pkg::div_cmd_t div_cmd;
	tkg_pkg::div_rsp_t div_rsp;

	logic         take;
	logic [31:0]  key;
	logic [7:0]   typ;
	logic [63:0]  nhdr;
	logic [1:0]   npad;
	logic [2:0]   width;
	logic [31:0]  nes;

	tkg_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .cmd(div_cmd), .rsp(div_rsp)
	);

	assign in_stall  = (state_q != ST_PARSE) || (in_data.packet_end && out_valid_q);
	assign take      = in_valid && !in_stall;
	assign key       = hdr_q[63:32];
	assign typ       = hdr_q[31:24];
	assign nhdr      = {hdr_q[55:0], in_data.data_byte};
	assign npad      = 2'(3'd4 - {1'b0, 2'(nhdr[23:16] * nhdr[1:0])});
	assign width     = (key == tkg_pkg::KEY_SCAL &&
		(typ == tkg_pkg::TYPE_USHORT || typ == tkg_pkg::TYPE_SSHORT)) ? 3'd2 : 3'd4;
	assign nes       = {eshift_q[23:0], in_data.data_byte};

	assign div_cmd.start = div_go_q;
	assign div_cmd.raw   = snap_raw_q[div_sel_q];
	assign div_cmd.scale = snap_scale_q[div_sel_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_PARSE;
			div_sel_q <= 2'd0;
			div_go_q  <= 1'b0;
			out_valid_q <= 1'b0;
			hdr_q     <= '0;
			hdr_pos_q <= '0;
			remain_q  <= '0;
			pad_q     <= '0;
			ebp_q     <= '0;
			eshift_q  <= '0;
			eidx_q    <= '0;
			utc_off_q <= '0;
			fix_q     <= '0;
			pflag_q   <= 1'b0;
			for (int i = 0; i < SCALE_ENTRIES; i++) scale_q[i] <= 32'd1;
			for (int i = 0; i < 3; i++) begin
				raw_q[i] <= '0;
				pscale_q[i] <= 32'd1;
			end
			for (int i = 0; i < 16; i++) utc_q[i] <= 8'h30;
		end else begin
			div_go_q <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (take) begin
				if (remain_q == 24'd0) begin
					hdr_q     <= nhdr;
					hdr_pos_q <= hdr_pos_q + 3'd1;
					if (hdr_pos_q == 3'd7 && nhdr[31:24] != tkg_pkg::TYPE_NEST) begin
						pad_q     <= npad;
						remain_q  <= 24'(nhdr[23:16]) * 24'(nhdr[15:0]) + 24'(npad);
						ebp_q     <= '0;
						eshift_q  <= '0;
						eidx_q    <= '0;
						utc_off_q <= '0;
						if (nhdr[63:32] == tkg_pkg::KEY_GPS5 && nhdr[15:0] != 16'd0) begin
							for (int i = 0; i < 3; i++) begin
								raw_q[i]    <= '0;
								pscale_q[i] <= scale_q[i];
							end
							pflag_q <= 1'b1;
						end
					end
				end else begin
					if (remain_q > 24'(pad_q)) begin
						if (typ == tkg_pkg::TYPE_UTC && !utc_off_q[4]) begin
							utc_q[utc_off_q[3:0]] <= in_data.data_byte;
							utc_off_q <= utc_off_q + 5'd1;
						end
						if (ebp_q + 3'd1 >= width) begin
							ebp_q    <= '0;
							eshift_q <= '0;
							if (key == tkg_pkg::KEY_SCAL) begin
								if (32'(eidx_q) < SCALE_ENTRIES)
									scale_q[eidx_q[SW-1:0]] <= nes;
							end else if (key == tkg_pkg::KEY_GPSF) begin
								if (typ == tkg_pkg::TYPE_ULONG && eidx_q == 4'd0)
									fix_q <= nes;
							end else if (key == tkg_pkg::KEY_GPS5) begin
								if (eidx_q < 4'd3) raw_q[eidx_q[1:0]] <= nes;
							end
							if (eidx_q != tkg_pkg::ELEM_IDX_MAX) eidx_q <= eidx_q + 4'd1;
						end else begin
							ebp_q    <= ebp_q + 3'd1;
							eshift_q <= nes;
						end
					end
					remain_q <= remain_q - 24'd1;
				end
				if (in_data.packet_end) begin
					// Snapshot after this byte's effect, computed from the same inputs.
					snap_raw_q   <= raw_q;
					snap_scale_q <= pscale_q;
					if (remain_q == 24'd0 && hdr_pos_q == 3'd7 &&
						nhdr[31:24] != tkg_pkg::TYPE_NEST &&
						nhdr[63:32] == tkg_pkg::KEY_GPS5 && nhdr[15:0] != 16'd0) begin
						for (int i = 0; i < 3; i++) begin
							snap_raw_q[i]   <= '0;
							snap_scale_q[i] <= scale_q[i];
						end
					end else if (remain_q != 24'd0 && remain_q > 24'(pad_q) &&
						key == tkg_pkg::KEY_GPS5 && ebp_q + 3'd1 >= width && eidx_q < 4'd3) begin
						snap_raw_q[eidx_q[1:0]] <= nes;
					end
					res_q.gps_fix <= fix_q;
					if (remain_q != 24'd0 && remain_q > 24'(pad_q) &&
						key == tkg_pkg::KEY_GPSF && typ == tkg_pkg::TYPE_ULONG &&
						ebp_q + 3'd1 >= width && eidx_q == 4'd0)
						res_q.gps_fix <= nes;
					res_q.position_seen <= pflag_q || (remain_q == 24'd0 && hdr_pos_q == 3'd7
						&& nhdr[31:24] != tkg_pkg::TYPE_NEST
						&& nhdr[63:32] == tkg_pkg::KEY_GPS5 && nhdr[15:0] != 16'd0);
					// packet state clears
					hdr_q     <= '0;
					hdr_pos_q <= '0;
					remain_q  <= '0;
					pad_q     <= '0;
					ebp_q     <= '0;
					eshift_q  <= '0;
					eidx_q    <= '0;
					utc_off_q <= '0;
					fix_q     <= '0;
					pflag_q   <= 1'b0;
					for (int i = 0; i < SCALE_ENTRIES; i++) scale_q[i] <= 32'd1;
					for (int i = 0; i < 3; i++) begin
						raw_q[i] <= '0;
						pscale_q[i] <= 32'd1;
					end
					div_sel_q <= 2'd0;
					div_go_q  <= 1'b1;
					state_q   <= ST_DIV;
				end
			end
			case (state_q)
				ST_PARSE: ;
				ST_DIV: begin
					state_q <= ST_WAIT;
					// UTC digits settle in the cycle after the last byte was written.
					res_q.utc_year   <= 7'(tkg_pkg::digit_val(utc_q[0]) * 10
						+ tkg_pkg::digit_val(utc_q[1]));
					res_q.utc_month  <= 7'(tkg_pkg::digit_val(utc_q[2]) * 10
						+ tkg_pkg::digit_val(utc_q[3]));
					res_q.utc_day    <= 7'(tkg_pkg::digit_val(utc_q[4]) * 10
						+ tkg_pkg::digit_val(utc_q[5]));
					res_q.utc_hour   <= 7'(tkg_pkg::digit_val(utc_q[6]) * 10
						+ tkg_pkg::digit_val(utc_q[7]));
					res_q.utc_minute <= 7'(tkg_pkg::digit_val(utc_q[8]) * 10
						+ tkg_pkg::digit_val(utc_q[9]));
					res_q.utc_second <= 7'(tkg_pkg::digit_val(utc_q[10]) * 10
						+ tkg_pkg::digit_val(utc_q[11]));
					res_q.utc_millis <= 10'(tkg_pkg::digit_val(utc_q[13]) * 100
						+ tkg_pkg::digit_val(utc_q[14]) * 10
						+ tkg_pkg::digit_val(utc_q[15]));
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						if (div_sel_q == 2'd2) begin
							out_q <= '{gps_fix: res_q.gps_fix,
								latitude_q: quot_q[0], longitude_q: quot_q[1],
								elevation_q: div_rsp.quot,
								position_seen: res_q.position_seen,
								utc_year: res_q.utc_year, utc_month: res_q.utc_month,
								utc_day: res_q.utc_day, utc_hour: res_q.utc_hour,
								utc_minute: res_q.utc_minute,
								utc_second: res_q.utc_second,
								utc_millis: res_q.utc_millis};
							out_valid_q <= 1'b1;
							state_q     <= ST_PARSE;
						end else begin
							quot_q[div_sel_q[0]] <= div_rsp.quot;
							div_sel_q <= div_sel_q + 2'd1;
							div_go_q  <= 1'b1;
						end
					end
				end
				default: state_q <= ST_PARSE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

/* rtl/core/tkg_checker.sv */
// ----------------------------------------------------------------------------
// tkg_checker: port-level checks for the KLV position extractor
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module tkg_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input tkg_pkg::in_req_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input tkg_pkg::out_req_t out_data
);
	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// A packet end is followed by a stall while the divisions run.
	a_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.packet_end |=> in_stall)
		else $error("no stall after packet end");
	// No latitude quotient without a sample.
	a_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.position_seen |-> out_data.latitude_q == 64'd0)
		else $error("position without sample");
	// The month stays in its two-digit range and the milliseconds in three digits.
	a_utc_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.utc_month <= 7'd99 && out_data.utc_millis <= 10'd999)
		else $error("date field out of range");
endmodule

bind telemetry_klv_gps_extractor_core tkg_checker u_tkg_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the telemetry KLV position extractor
// Streams KLV packets (nested headers, scale lists, fix words, position
// samples, date items and raw noise) into the core with random gaps on both
// channels. A model of the parser predicts each end-of-packet result, and the
// scoreboard compares every result field by field, oldest first.
// ----------------------------------------------------------------------------
class position_scoreboard;
	logic [63:0] hdr_shift;
	int unsigned hdr_pos;
	logic [31:0] remaining;
	logic [31:0] pad_len;
	int unsigned byte_pos;
	logic [31:0] elem_shift;
	int unsigned elem_idx;
	int unsigned date_off;
	logic [31:0] scales [5];
	logic [31:0] fix;
	logic [31:0] pos_raw [3];
	logic [31:0] pos_scale [3];
	logic [7:0] date_chars [16];
	logic pos_flag;
	tkg_pkg::out_req_t pending_results[$];
	int errors;

	function new();
		errors = 0;
		foreach (date_chars[i]) date_chars[i] = 8'h30;
		clear_packet();
	endfunction

	function void clear_packet();
		hdr_shift = '0;
		hdr_pos = 0;
		remaining = '0;
		pad_len = '0;
		byte_pos = 0;
		elem_shift = '0;
		elem_idx = 0;
		date_off = 0;
		foreach (scales[i]) scales[i] = 32'd1;
		fix = '0;
		foreach (pos_raw[i]) begin
			pos_raw[i] = '0;
			pos_scale[i] = 32'd1;
		end
		pos_flag = 1'b0;
	endfunction

	function logic [63:0] quotient(logic [31:0] raw, logic [31:0] scale);
		logic [63:0] mag;
		logic [63:0] q;
		mag = raw[31] ? {32'd0, -raw} : {32'd0, raw};
		if (scale == 0) begin
			if (raw == 0)
				return '0;
			return raw[31] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
		q = (mag << 32) / {32'd0, scale};
		return raw[31] ? -q : q;
	endfunction

	function logic [9:0] digit(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) ? 10'(c - 8'h30) : 10'd0;
	endfunction

	function void store_element(logic [31:0] key, logic [7:0] kind, logic [31:0] value);
		if (key == tkg_pkg::KEY_SCAL) begin
			if (elem_idx < 5)
				scales[elem_idx] = value;
		end else if (key == tkg_pkg::KEY_GPSF) begin
			if (kind == tkg_pkg::TYPE_ULONG && elem_idx == 0)
				fix = value;
		end else if (key == tkg_pkg::KEY_GPS5) begin
			if (elem_idx < 3)
				pos_raw[elem_idx] = value;
		end
		if (elem_idx < 15)
			elem_idx++;
	endfunction

	// Notes one accepted request and queues the result it causes, if any.
	function void note_request(tkg_pkg::in_req_t req);
		logic [31:0] key;
		logic [7:0] kind;
		logic [31:0] len;
		int unsigned width;
		tkg_pkg::out_req_t r;
		key = hdr_shift[63:32];
		kind = hdr_shift[31:24];
		if (remaining == 0) begin
			hdr_shift = {hdr_shift[55:0], req.data_byte};
			hdr_pos++;
			if (hdr_pos >= 8) begin
				hdr_pos = 0;
				key = hdr_shift[63:32];
				kind = hdr_shift[31:24];
				if (kind != tkg_pkg::TYPE_NEST) begin
					len = {24'd0, hdr_shift[23:16]} * {16'd0, hdr_shift[15:0]};
					pad_len = (32'd4 - {30'd0, len[1:0]}) & 32'd3;
					remaining = len + pad_len;
					byte_pos = 0;
					elem_shift = '0;
					elem_idx = 0;
					date_off = 0;
					if (key == tkg_pkg::KEY_GPS5 && hdr_shift[15:0] != 0) begin
						foreach (pos_raw[i]) begin
							pos_raw[i] = '0;
							pos_scale[i] = scales[i];
						end
						pos_flag = 1'b1;
					end
				end
			end
		end else begin
			if (remaining > pad_len) begin
				if (kind == tkg_pkg::TYPE_UTC && date_off < 16) begin
					date_chars[date_off] = req.data_byte;
					date_off++;
				end
				width = (key == tkg_pkg::KEY_SCAL && (kind == tkg_pkg::TYPE_USHORT
					|| kind == tkg_pkg::TYPE_SSHORT)) ? 2 : 4;
				elem_shift = {elem_shift[23:0], req.data_byte};
				byte_pos++;
				if (byte_pos >= width) begin
					store_element(key, kind, elem_shift);
					byte_pos = 0;
					elem_shift = '0;
				end
			end
			remaining--;
		end
		if (!req.packet_end)
			return;
		r.gps_fix = fix;
		r.latitude_q = quotient(pos_raw[0], pos_scale[0]);
		r.longitude_q = quotient(pos_raw[1], pos_scale[1]);
		r.elevation_q = quotient(pos_raw[2], pos_scale[2]);
		r.position_seen = pos_flag;
		r.utc_year = 7'(digit(date_chars[0]) * 10 + digit(date_chars[1]));
		r.utc_month = 7'(digit(date_chars[2]) * 10 + digit(date_chars[3]));
		r.utc_day = 7'(digit(date_chars[4]) * 10 + digit(date_chars[5]));
		r.utc_hour = 7'(digit(date_chars[6]) * 10 + digit(date_chars[7]));
		r.utc_minute = 7'(digit(date_chars[8]) * 10 + digit(date_chars[9]));
		r.utc_second = 7'(digit(date_chars[10]) * 10 + digit(date_chars[11]));
		r.utc_millis = 10'(digit(date_chars[13]) * 100 + digit(date_chars[14]) * 10
			+ digit(date_chars[15]));
		pending_results.push_back(r);
		clear_packet();
	endfunction

	function void check_result(tkg_pkg::out_req_t got);
		tkg_pkg::out_req_t e;
		if (pending_results.size() == 0) begin
			$error("unexpected result, fix %h", got.gps_fix);
			errors++;
			return;
		end
		e = pending_results.pop_front();
		if (got.gps_fix !== e.gps_fix) begin
			$error("gps_fix: expected %h, got %h", e.gps_fix, got.gps_fix); errors++;
		end
		if (got.latitude_q !== e.latitude_q) begin
			$error("latitude_q: expected %h, got %h", e.latitude_q, got.latitude_q); errors++;
		end
		if (got.longitude_q !== e.longitude_q) begin
			$error("longitude_q: expected %h, got %h", e.longitude_q, got.longitude_q);
			errors++;
		end
		if (got.elevation_q !== e.elevation_q) begin
			$error("elevation_q: expected %h, got %h", e.elevation_q, got.elevation_q);
			errors++;
		end
		if (got.position_seen !== e.position_seen) begin
			$error("position_seen: expected %b, got %b", e.position_seen, got.position_seen);
			errors++;
		end
		if (got.utc_year !== e.utc_year) begin
			$error("utc_year: expected %0d, got %0d", e.utc_year, got.utc_year); errors++;
		end
		if (got.utc_month !== e.utc_month) begin
			$error("utc_month: expected %0d, got %0d", e.utc_month, got.utc_month); errors++;
		end
		if (got.utc_day !== e.utc_day) begin
			$error("utc_day: expected %0d, got %0d", e.utc_day, got.utc_day); errors++;
		end
		if (got.utc_hour !== e.utc_hour) begin
			$error("utc_hour: expected %0d, got %0d", e.utc_hour, got.utc_hour); errors++;
		end
		if (got.utc_minute !== e.utc_minute) begin
			$error("utc_minute: expected %0d, got %0d", e.utc_minute, got.utc_minute);
			errors++;
		end
		if (got.utc_second !== e.utc_second) begin
			$error("utc_second: expected %0d, got %0d", e.utc_second, got.utc_second);
			errors++;
		end
		if (got.utc_millis !== e.utc_millis) begin
			$error("utc_millis: expected %0d, got %0d", e.utc_millis, got.utc_millis);
			errors++;
		end
	endfunction
endclass

module tb;
	// A packet end costs three serial divisions.
	localparam int DRAIN_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 1_500_000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	tkg_pkg::in_req_t in_data;
	logic out_valid;
	logic out_stall;
	tkg_pkg::out_req_t out_data;

	position_scoreboard board;
	longint cycle_count;
	int unsigned results_seen;
	// While set, the receiver holds off completely so that the core backs up.
	logic hold_output;
	logic hold_request;
	// Bytes of the packet being built, sent byte by byte with random gaps.
	logic [7:0] packet_bytes[$];

	telemetry_klv_gps_extractor_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then long.
	function automatic int unsigned gap_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sends one byte after a random gap and waits for its acceptance, then
	// notes the request. Valid stays high into the next call unless a gap
	// follows; after the last byte of a packet it is dropped.
	task automatic send_byte(logic [7:0] b, logic last);
		int unsigned gap;
		tkg_pkg::in_req_t req;
		gap = gap_length();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.data_byte = b;
		req.packet_end = last;
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(req);
		if (last) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic push_header(logic [31:0] key, logic [7:0] kind, logic [7:0] size,
			logic [15:0] count);
		packet_bytes.push_back(key[31:24]);
		packet_bytes.push_back(key[23:16]);
		packet_bytes.push_back(key[15:8]);
		packet_bytes.push_back(key[7:0]);
		packet_bytes.push_back(kind);
		packet_bytes.push_back(size);
		packet_bytes.push_back(count[15:8]);
		packet_bytes.push_back(count[7:0]);
	endtask

	task automatic push_word(logic [31:0] w);
		packet_bytes.push_back(w[31:24]);
		packet_bytes.push_back(w[23:16]);
		packet_bytes.push_back(w[15:8]);
		packet_bytes.push_back(w[7:0]);
	endtask

	// Random payload of a given length followed by zero padding.
	task automatic push_payload(int unsigned len);
		repeat (len) packet_bytes.push_back(8'($urandom));
		repeat ((4 - len % 4) % 4) packet_bytes.push_back(8'h00);
	endtask

	task automatic send_packet();
		int unsigned n;
		n = packet_bytes.size();
		for (int unsigned i = 0; i < n; i++)
			send_byte(packet_bytes[i], i == n - 1);
		packet_bytes.delete();
	endtask

	function automatic logic [31:0] random_scale();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 32'd0;
		if (roll == 1)
			return 32'hFFFF_FFFF;
		if (roll < 5)
			return $urandom_range(1, 10_000_000);
		return $urandom;
	endfunction

	function automatic logic [31:0] random_raw();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 32'h8000_0000;
		if (roll == 1)
			return 32'h7FFF_FFFF;
		if (roll == 2)
			return 32'd0;
		return $urandom;
	endfunction

	// Date item: mostly proper digits, sometimes other characters or short.
	task automatic push_date(int unsigned len);
		push_header(32'h4755_534D, tkg_pkg::TYPE_UTC, 8'd1, 16'(len));
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				packet_bytes.push_back(8'($urandom));
			else
				packet_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
		end
		repeat ((4 - len % 4) % 4) packet_bytes.push_back(8'h00);
	endtask

	// One packet of random shape and content, at times cut short or ended with noise.
	task automatic build_packet();
		int unsigned n_items;
		int unsigned roll;
		int unsigned cnt;
		n_items = $urandom_range(1, 5);
		if ($urandom_range(0, 1))
			push_header(32'h4445_5643, tkg_pkg::TYPE_NEST, 8'd1,
				16'($urandom_range(0, 400)));
		for (int unsigned k = 0; k < n_items; k++) begin
			roll = $urandom_range(0, 9);
			case (roll)
				0, 1: begin
					cnt = $urandom_range(0, 7);
					if ($urandom_range(0, 1)) begin
						push_header(tkg_pkg::KEY_SCAL, $urandom_range(0, 1)
							? tkg_pkg::TYPE_USHORT : tkg_pkg::TYPE_SSHORT, 8'd2, 16'(cnt));
						push_payload(2 * cnt);
					end else begin
						push_header(tkg_pkg::KEY_SCAL, 8'h6C, 8'd4, 16'(cnt));
						for (int unsigned i = 0; i < cnt; i++) push_word(random_scale());
					end
				end
				2, 3: begin
					cnt = $urandom_range(0, 3);
					push_header(tkg_pkg::KEY_GPS5, 8'h6C,
						$urandom_range(0, 5) == 0 ? 8'd6 : 8'd20, 16'(cnt));
					for (int unsigned i = 0; i < cnt * 5; i++) push_word(random_raw());
				end
				4: begin
					cnt = $urandom_range(0, 2);
					push_header(tkg_pkg::KEY_GPSF,
						$urandom_range(0, 3) == 0 ? 8'h6C : tkg_pkg::TYPE_ULONG,
						8'd4, 16'(cnt));
					for (int unsigned i = 0; i < cnt; i++) push_word($urandom);
				end
				5: begin
					cnt = $urandom_range(0, 3);
					push_header(tkg_pkg::KEY_GPSF, tkg_pkg::TYPE_ULONG, 8'(cnt), 16'd1);
					push_payload(cnt);
				end
				6, 7: push_date($urandom_range(0, 1) ? 16 : $urandom_range(0, 20));
				8: begin
					push_header($urandom, 8'($urandom_range(1, 255)), 8'($urandom_range(0, 9)),
						16'($urandom_range(0, 5)));
					push_payload((packet_bytes[packet_bytes.size() - 3]) *
						(packet_bytes[packet_bytes.size() - 1]));
				end
				default: push_header($urandom_range(0, 1) ? tkg_pkg::KEY_GPS5
					: tkg_pkg::KEY_SCAL, tkg_pkg::TYPE_NEST, 8'($urandom), 16'($urandom));
			endcase
		end
		// Sometimes cut the packet short, or end it with noise.
		roll = $urandom_range(0, 9);
		if (roll == 0 && packet_bytes.size() > 3)
			repeat ($urandom_range(1, 3)) void'(packet_bytes.pop_back());
		else if (roll == 1)
			repeat ($urandom_range(1, 6)) packet_bytes.push_back(8'($urandom));
	endtask

	task automatic wait_for_results();
		while (board.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stall, or one long hold-off once hold_request is set.
	initial begin
		int unsigned stall_left;
		logic hold_spent;
		out_stall = 1'b1;
		stall_left = 0;
		results_seen = 0;
		hold_output = 1'b0;
		hold_spent = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				board.check_result(out_data);
				results_seen++;
			end
			if (hold_request && !hold_spent) begin
				hold_spent = 1'b1;
				hold_output = 1'b1;
				out_stall <= 1'b1;
				repeat (1500) @(posedge clk);
				hold_output = 1'b0;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = gap_length();
				out_stall <= (stall_left != 0);
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		tkg_pkg::in_req_t idle_req;
		int unsigned byte_total;
		int unsigned drain;
		board = new();
		idle_req = '0;
		in_valid = 1'b0;
		in_data = idle_req;
		hold_request = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a packet of only an end byte, then a full sample with date.
		packet_bytes.push_back(8'hFF);
		send_packet();
		push_header(32'h4445_5643, tkg_pkg::TYPE_NEST, 8'd1, 16'd0);
		push_header(tkg_pkg::KEY_SCAL, tkg_pkg::TYPE_SSHORT, 8'd2, 16'd6);
		push_word(32'h0001_FFFF); push_word(32'h0000_000A); push_word(32'h0003_0004);
		push_header(tkg_pkg::KEY_GPSF, tkg_pkg::TYPE_ULONG, 8'd4, 16'd1);
		push_word(32'hFFFF_FFFF);
		push_header(tkg_pkg::KEY_GPS5, 8'h6C, 8'd20, 16'd1);
		push_word(32'h8000_0000); push_word(32'h7FFF_FFFF); push_word(32'h0000_0000);
		push_word(32'h1); push_word(32'h2);
		push_header(32'h4755_534D, tkg_pkg::TYPE_UTC, 8'd1, 16'd16);
		push_word(32'h3939_3132); push_word(32'h3331_3233); push_word(32'h3539_2E39);
		push_word(32'h3939_413A);
		send_packet();
		wait_for_results();

		// Random packets. Partway through, the receiver holds off while packets
		// keep coming, and once the sender waits until every result is back.
		byte_total = 0;
		for (int p = 0; byte_total < 1400; p++) begin
			build_packet();
			byte_total += packet_bytes.size();
			if (p == 6)
				hold_request = 1'b1;
			send_packet();
			if (p == 12)
				wait_for_results();
		end
		wait_for_results();
		drain = 0;
		while (drain < DRAIN_CYCLES) begin
			@(posedge clk);
			drain++;
		end
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
